// File: rtl/dds_pkg.sv
package dds_pkg;

  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 11;
  localparam int SpeedW   = 15;
  localparam int LenW     = 10;

  localparam logic [CfgAddrW-1:0] REG_BASE_SPEED    = 3'd0;
  localparam logic [CfgAddrW-1:0] REG_MAX_SPEED     = 3'd1;
  localparam logic [CfgAddrW-1:0] REG_MIN_SPEED     = 3'd2;
  localparam logic [CfgAddrW-1:0] REG_ACCEL_STEP    = 3'd3;
  localparam logic [CfgAddrW-1:0] REG_DEADBAND      = 3'd4;
  localparam logic [CfgAddrW-1:0] REG_MAX_PROP_DIFF = 3'd5;

  localparam logic signed [10:0] BASE_SPEED_RST    = 11'sd50;
  localparam logic signed [10:0] MAX_SPEED_RST     = 11'sd150;
  localparam logic signed [10:0] MIN_SPEED_RST     = -11'sd150;
  localparam logic [7:0]         ACCEL_STEP_RST    = 8'd5;
  localparam logic [9:0]         DEADBAND_RST      = 10'd10;
  localparam logic [9:0]         MAX_PROP_DIFF_RST = 10'd200;

  // base speed reset times sixteen
  localparam logic signed [SpeedW-1:0] SPEED_NOW_RST = 15'sd800;

  localparam logic [10:0] ERR_LIMIT = 11'd250;

  // x / 125 == (x * RECIP_125) >> RECIP_SHIFT for all x below 2**20
  localparam logic [20:0] RECIP_125   = 21'd1073742;
  localparam int          RECIP_SHIFT = 27;
  localparam logic [19:0] ROUND_BIAS  = 20'd62;

endpackage

// File: rtl/diff_drive_steering_slew_unit.sv
// Pipeline: each accepted item is registered in stage A, then stage B, then the stage C output register.
// Throughput: one item per cycle; the stages advance together whenever the
// output register is empty or being taken.
// Reset (rst_n low, synchronous): registers return to their defaults, both
// wheel speeds to 800 (base speed times sixteen), the pipeline empties.
module diff_drive_steering_slew_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [dds_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [dds_pkg::CfgDataW-1:0] cfg_wdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [23:0]                  in_tdata,   // left_length, right_length
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata   // left_speed, right_speed
);

  logic signed [10:0] base_speed_r, max_speed_r, min_speed_r;
  logic [7:0]         accel_step_r;
  logic [9:0]         deadband_r, max_prop_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_speed_r    <= dds_pkg::BASE_SPEED_RST;
      max_speed_r     <= dds_pkg::MAX_SPEED_RST;
      min_speed_r     <= dds_pkg::MIN_SPEED_RST;
      accel_step_r    <= dds_pkg::ACCEL_STEP_RST;
      deadband_r      <= dds_pkg::DEADBAND_RST;
      max_prop_diff_r <= dds_pkg::MAX_PROP_DIFF_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        dds_pkg::REG_BASE_SPEED:    base_speed_r    <= $signed(cfg_wdata);
        dds_pkg::REG_MAX_SPEED:     max_speed_r     <= $signed(cfg_wdata);
        dds_pkg::REG_MIN_SPEED:     min_speed_r     <= $signed(cfg_wdata);
        dds_pkg::REG_ACCEL_STEP:    accel_step_r    <= cfg_wdata[7:0];
        dds_pkg::REG_DEADBAND:      deadband_r      <= cfg_wdata[9:0];
        dds_pkg::REG_MAX_PROP_DIFF: max_prop_diff_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic out_valid_r;
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = advance;

  // stage A: difference, deadband test, error product
  logic [9:0]         left_len, right_len;
  logic signed [10:0] diff;
  logic               diff_neg;
  logic [10:0]        mag;
  logic [7:0]         err_mag;
  logic [17:0]        prod_nxt;

  assign left_len  = in_tdata[9:0];
  assign right_len = in_tdata[19:10];

  always_comb begin
    diff     = $signed({1'b0, left_len}) - $signed({1'b0, right_len});
    diff_neg = diff[10];
    mag      = diff_neg ? 11'(-diff) : 11'(diff);
    err_mag  = (mag > dds_pkg::ERR_LIMIT) ? dds_pkg::ERR_LIMIT[7:0] : mag[7:0];
    prod_nxt = 18'(err_mag) * 18'(max_prop_diff_r);
  end

  logic        va_r, neg_a_r, db_a_r;
  logic [17:0] prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (advance) begin
      va_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r  <= prod_nxt;
      neg_a_r <= diff_neg;
      db_a_r  <= (mag < {1'b0, deadband_r});
    end
  end

  // stage B: rounded divide by 125
  logic [19:0] scaled;
  logic [40:0] recip_prod;
  logic [12:0] half_mag_nxt;

  always_comb begin
    scaled       = {prod_r, 2'b00} + dds_pkg::ROUND_BIAS;
    recip_prod   = 41'(scaled) * 41'(dds_pkg::RECIP_125);
    half_mag_nxt = recip_prod[dds_pkg::RECIP_SHIFT +: 13];
  end

  logic        vb_r, neg_b_r, db_b_r;
  logic [12:0] half_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (advance) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      half_mag_r <= half_mag_nxt;
      neg_b_r    <= neg_a_r;
      db_b_r     <= db_a_r;
    end
  end

  // stage C: targets, clamp, slew
  logic signed [dds_pkg::SpeedW-1:0] left_now_r, right_now_r;
  logic signed [dds_pkg::SpeedW-1:0] left_now_nxt, right_now_nxt;
  logic signed [16:0] half, base16, lo16, hi16, step16;
  logic signed [16:0] tgt_l, tgt_r;

  function automatic logic signed [16:0] clip17(
    input logic signed [16:0] v,
    input logic signed [16:0] lo,
    input logic signed [16:0] hi
  );
    logic signed [16:0] t;
    t = (v > hi) ? hi : v;
    t = (t < lo) ? lo : t;
    return t;
  endfunction

  function automatic logic signed [dds_pkg::SpeedW-1:0] slew15(
    input logic signed [dds_pkg::SpeedW-1:0] now,
    input logic signed [16:0]                tgt,
    input logic signed [16:0]                step
  );
    logic signed [16:0] now17, up, dn, res;
    now17 = 17'(now);
    up    = now17 + step;
    dn    = now17 - step;
    if (tgt > now17) begin
      res = (up < tgt) ? up : tgt;
    end else if (tgt < now17) begin
      res = (dn > tgt) ? dn : tgt;
    end else begin
      res = tgt;
    end
    return res[dds_pkg::SpeedW-1:0];
  endfunction

  always_comb begin
    half   = neg_b_r ? -$signed({4'b0, half_mag_r}) : $signed({4'b0, half_mag_r});
    base16 = 17'($signed({base_speed_r, 4'b0000}));
    lo16   = 17'($signed({min_speed_r, 4'b0000}));
    hi16   = 17'($signed({max_speed_r, 4'b0000}));
    step16 = $signed({5'b0, accel_step_r, 4'b0000});
    if (db_b_r) begin
      tgt_l = base16;
      tgt_r = base16;
    end else begin
      tgt_l = clip17(base16 - half, lo16, hi16);
      tgt_r = clip17(base16 + half, lo16, hi16);
    end
    left_now_nxt  = slew15(left_now_r, tgt_l, step16);
    right_now_nxt = slew15(right_now_r, tgt_r, step16);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_now_r  <= dds_pkg::SPEED_NOW_RST;
      right_now_r <= dds_pkg::SPEED_NOW_RST;
    end else if (advance) begin
      out_valid_r <= vb_r;
      if (vb_r) begin
        left_now_r  <= left_now_nxt;
        right_now_r <= right_now_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, right_now_r, left_now_r};

endmodule

// File: sim/tb_diff_drive_steering_slew_unit.sv
module tb_diff_drive_steering_slew_unit;

  localparam int PlanLen       = 42;
  localparam int Phases        = 8;
  localparam int PhaseItems    = 156;
  localparam int LongHold      = 80;
  localparam int WatchdogLimit = 1000;
  localparam int TailCycles    = 10;
  localparam int HalfDiv       = 125;
  localparam int HalfBias      = 62;
  localparam int LenMax        = 1023;

  localparam logic [dds_pkg::CfgAddrW-1:0] REG_UNMAPPED_6 = 3'd6;
  localparam logic [dds_pkg::CfgAddrW-1:0] REG_UNMAPPED_7 = 3'd7;

  typedef enum bit {ROW_ITEM, ROW_WRITE} row_kind_t;

  // item row: a = left_length, b = right_length; write row: a = register, b = data
  typedef struct {
    row_kind_t kind;
    int        a;
    int        b;
    bit        typed;
    int        exp_l;
    int        exp_r;
  } row_t;

  typedef struct {
    logic signed [dds_pkg::SpeedW-1:0] left;
    logic signed [dds_pkg::SpeedW-1:0] right;
  } speeds_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         cfg_we = 1'b0;
  logic [dds_pkg::CfgAddrW-1:0] cfg_addr = '0;
  logic [dds_pkg::CfgDataW-1:0] cfg_wdata = '0;
  logic                         in_tvalid = 1'b0;
  logic                         in_tready;
  logic [23:0]                  in_tdata = '0;   // left_length, right_length
  logic                         out_tvalid;
  logic                         out_tready = 1'b0;
  logic [31:0]                  out_tdata;       // left_speed, right_speed

  int base_spd   = int'(dds_pkg::BASE_SPEED_RST);
  int max_spd    = int'(dds_pkg::MAX_SPEED_RST);
  int min_spd    = int'(dds_pkg::MIN_SPEED_RST);
  int accel      = int'(dds_pkg::ACCEL_STEP_RST);
  int dead_band  = int'(dds_pkg::DEADBAND_RST);
  int prop_diff  = int'(dds_pkg::MAX_PROP_DIFF_RST);
  int left_now   = int'(dds_pkg::BASE_SPEED_RST) * 16;
  int right_now  = int'(dds_pkg::BASE_SPEED_RST) * 16;

  speeds_t pending_speeds[$];
  int      mismatch_count = 0;
  int      hold_requests  = 0;
  int      holds_served   = 0;
  int      idle_cycles    = 0;

  row_t plan [PlanLen] = '{
    '{ROW_ITEM,  0,    0,    1'b1, 800, 800},
    '{ROW_ITEM,  1023, 0,    1'b1, 720, 880},
    '{ROW_ITEM,  0,    1023, 1'b1, 800, 800},
    '{ROW_ITEM,  5,    14,   1'b0, 0, 0},
    '{ROW_ITEM,  14,   4,    1'b0, 0, 0},
    '{ROW_ITEM,  300,  50,   1'b0, 0, 0},
    '{ROW_ITEM,  50,   301,  1'b0, 0, 0},
    '{ROW_ITEM,  512,  511,  1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_DEADBAND, 0, 1'b0, 0, 0},
    '{ROW_ITEM,  7,    7,    1'b0, 0, 0},
    '{ROW_ITEM,  1,    0,    1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_DEADBAND, 1023, 1'b0, 0, 0},
    '{ROW_ITEM,  1023, 0,    1'b0, 0, 0},
    '{ROW_ITEM,  0,    1022, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_MIN_SPEED, 100, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_MAX_SPEED, -100, 1'b0, 0, 0},
    '{ROW_ITEM,  600,  100,  1'b0, 0, 0},
    '{ROW_ITEM,  100,  600,  1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_ACCEL_STEP, 0, 1'b0, 0, 0},
    '{ROW_ITEM,  1023, 0,    1'b0, 0, 0},
    '{ROW_ITEM,  0,    1023, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_ACCEL_STEP, 255, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_MIN_SPEED, -1023, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_MAX_SPEED, 1023, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_BASE_SPEED, 1023, 1'b0, 0, 0},
    '{ROW_ITEM,  0,    0,    1'b0, 0, 0},
    '{ROW_ITEM,  3,    0,    1'b0, 0, 0},
    '{ROW_ITEM,  0,    0,    1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_BASE_SPEED, -1024, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_MIN_SPEED, -1024, 1'b0, 0, 0},
    '{ROW_ITEM,  0,    0,    1'b0, 0, 0},
    '{ROW_ITEM,  1000, 1000, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_DEADBAND, 0, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_MAX_PROP_DIFF, 1023, 1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_BASE_SPEED, 0, 1'b0, 0, 0},
    '{ROW_ITEM,  1023, 0,    1'b0, 0, 0},
    '{ROW_ITEM,  0,    1023, 1'b0, 0, 0},
    '{ROW_WRITE, REG_UNMAPPED_6, 2047, 1'b0, 0, 0},
    '{ROW_WRITE, REG_UNMAPPED_7, 2047, 1'b0, 0, 0},
    '{ROW_ITEM,  600,  400,  1'b0, 0, 0},
    '{ROW_WRITE, dds_pkg::REG_MAX_PROP_DIFF, 0, 1'b0, 0, 0},
    '{ROW_ITEM,  900,  0,    1'b0, 0, 0}
  };

  diff_drive_steering_slew_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v;
  endfunction

  function automatic int slew_toward(int now, int tgt, int step);
    if (tgt > now) return (now + step < tgt) ? now + step : tgt;
    if (tgt < now) return (now - step > tgt) ? now - step : tgt;
    return tgt;
  endfunction

  function automatic void apply_reg(logic [dds_pkg::CfgAddrW-1:0] a,
                                    logic [dds_pkg::CfgDataW-1:0] d);
    case (a)
      dds_pkg::REG_BASE_SPEED:    base_spd  = int'($signed(d));
      dds_pkg::REG_MAX_SPEED:     max_spd   = int'($signed(d));
      dds_pkg::REG_MIN_SPEED:     min_spd   = int'($signed(d));
      dds_pkg::REG_ACCEL_STEP:    accel     = int'(d[7:0]);
      dds_pkg::REG_DEADBAND:      dead_band = int'(d[9:0]);
      dds_pkg::REG_MAX_PROP_DIFF: prop_diff = int'(d[9:0]);
      default: ;
    endcase
  endfunction

  function automatic speeds_t next_wheel_speeds(logic [dds_pkg::LenW-1:0] l,
                                                logic [dds_pkg::LenW-1:0] r);
    int      diff;
    int      err;
    int      half;
    int      lo;
    int      hi;
    int      tl;
    int      tr;
    speeds_t s;
    diff = int'(l) - int'(r);
    if ((diff < 0 ? -diff : diff) < dead_band) begin
      tl = base_spd * 16;
      tr = tl;
    end else begin
      err  = clamp_int(diff, -int'(dds_pkg::ERR_LIMIT), int'(dds_pkg::ERR_LIMIT));
      half = ((err < 0 ? -err : err) * prop_diff * 4 + HalfBias) / HalfDiv;
      if (err < 0) half = -half;
      lo = min_spd * 16;
      hi = max_spd * 16;
      if (lo > hi) begin
        tl = lo;
        tr = lo;
      end else begin
        tl = clamp_int(base_spd * 16 - half, lo, hi);
        tr = clamp_int(base_spd * 16 + half, lo, hi);
      end
    end
    left_now  = slew_toward(left_now, tl, accel * 16);
    right_now = slew_toward(right_now, tr, accel * 16);
    s.left  = left_now[dds_pkg::SpeedW-1:0];
    s.right = right_now[dds_pkg::SpeedW-1:0];
    return s;
  endfunction

  function automatic logic [dds_pkg::CfgDataW-1:0] pick_reg_value(
    logic [dds_pkg::CfgAddrW-1:0] a
  );
    int                           v;
    logic [31:0]                  raw;
    logic [dds_pkg::CfgDataW-1:0] junk;
    raw  = $urandom;
    junk = raw[dds_pkg::CfgDataW-1:0];
    case (a)
      dds_pkg::REG_BASE_SPEED, dds_pkg::REG_MAX_SPEED, dds_pkg::REG_MIN_SPEED: begin
        case ($urandom_range(0, 7))
          0: v = -1024;
          1: v = 1023;
          2: v = -1023;
          default: v = int'($urandom_range(0, 600)) - 300;
        endcase
        return v[dds_pkg::CfgDataW-1:0];
      end
      dds_pkg::REG_ACCEL_STEP: begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = 255;
          default: v = $urandom_range(1, 40);
        endcase
        return {junk[10:8], v[7:0]};
      end
      dds_pkg::REG_DEADBAND: begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = 1023;
          default: v = $urandom_range(0, 60);
        endcase
        return {junk[10], v[9:0]};
      end
      dds_pkg::REG_MAX_PROP_DIFF: begin
        case ($urandom_range(0, 7))
          0: v = 0;
          1: v = 1023;
          default: v = $urandom_range(0, 400);
        endcase
        return {junk[10], v[9:0]};
      end
      default: return junk;
    endcase
  endfunction

  task automatic offer_lengths(logic [dds_pkg::LenW-1:0] l, logic [dds_pkg::LenW-1:0] r,
                               bit typed, int el, int er);
    speeds_t s;
    cfg_we    <= 1'b0;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, r, l};
    do @(posedge clk); while (!in_tready);
    s = next_wheel_speeds(l, r);
    if (typed) begin
      s.left  = el[dds_pkg::SpeedW-1:0];
      s.right = er[dds_pkg::SpeedW-1:0];
    end
    pending_speeds.push_back(s);
  endtask

  task automatic pause_sender(int n);
    if (n > 0) begin
      in_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    if (pending_speeds.size() != 0) begin
      in_tvalid <= 1'b0;
      while (pending_speeds.size() != 0) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [dds_pkg::CfgAddrW-1:0] a,
                           logic [dds_pkg::CfgDataW-1:0] d);
    cfg_we    <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= d;
    @(posedge clk);
    apply_reg(a, d);
  endtask

  initial begin : stimulus
    int ll;
    int rl;
    int burst_left;
    int no_gap_until;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_WRITE) begin
        drain_results();
        write_reg(plan[k].a[dds_pkg::CfgAddrW-1:0], plan[k].b[dds_pkg::CfgDataW-1:0]);
      end else begin
        offer_lengths(plan[k].a[dds_pkg::LenW-1:0], plan[k].b[dds_pkg::LenW-1:0],
                      plan[k].typed, plan[k].exp_l, plan[k].exp_r);
        if ($urandom_range(0, 2) == 0) pause_sender($urandom_range(1, 4));
      end
    end

    for (int p = 0; p < Phases; p++) begin
      drain_results();
      for (int a = 0; a < 8; a++) begin
        write_reg(a[dds_pkg::CfgAddrW-1:0], pick_reg_value(a[dds_pkg::CfgAddrW-1:0]));
      end
      burst_left   = $urandom_range(1, 30);
      no_gap_until = 0;
      for (int i = 0; i < PhaseItems; i++) begin
        rl = $urandom_range(0, LenMax);
        case ($urandom_range(0, 7))
          0, 1:    ll = $urandom_range(0, LenMax);
          2, 3, 4: ll = rl + int'($urandom_range(0, 2 * dead_band + 10)) - dead_band - 5;
          5, 6:    ll = rl + int'($urandom_range(0, 600)) - 300;
          default: begin
            rl = $urandom_range(0, 1) ? LenMax : 0;
            ll = $urandom_range(0, 1) ? LenMax : 0;
          end
        endcase
        ll = clamp_int(ll, 0, LenMax);
        // stall the output for a long stretch while items keep coming
        if (p == 2 && i == 10) begin
          hold_requests++;
          no_gap_until = i + 40;
        end
        if (p == 4 && i == 60) drain_results();
        offer_lengths(ll[dds_pkg::LenW-1:0], rl[dds_pkg::LenW-1:0], 1'b0, 0, 0);
        burst_left--;
        if (burst_left == 0) begin
          if (i >= no_gap_until) pause_sender($urandom_range(1, 12));
          burst_left = $urandom_range(1, 30);
        end
      end
    end

    drain_results();
    repeat (TailCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : result_pacing
    int run_left;
    run_left = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        holds_served = hold_requests;
        out_tready <= 1'b0;
        run_left = LongHold;
      end else if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(0, 3) != 0) begin
        out_tready <= 1'b1;
        run_left = $urandom_range(0, ($urandom_range(0, 7) == 0) ? 40 : 8);
      end else begin
        out_tready <= 1'b0;
        run_left = $urandom_range(0, 4);
      end
    end
  end

  always @(posedge clk) begin : result_check
    speeds_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_speeds.size() == 0) begin
        $error("unexpected result: left_speed %0d, right_speed %0d",
               $signed(out_tdata[14:0]), $signed(out_tdata[29:15]));
        mismatch_count++;
      end else begin
        want = pending_speeds.pop_front();
        if (out_tdata[14:0] !== want.left) begin
          $error("left_speed: expected %0d, got %0d", want.left, $signed(out_tdata[14:0]));
          mismatch_count++;
        end
        if (out_tdata[29:15] !== want.right) begin
          $error("right_speed: expected %0d, got %0d", want.right, $signed(out_tdata[29:15]));
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

endmodule

// File: filelist.f
rtl/dds_pkg.sv
rtl/diff_drive_steering_slew_unit.sv
sim/tb_diff_drive_steering_slew_unit.sv
